FILE: design/cwpq_pkg.sv
// shared types and constants of the class window progress query block
package cwpq_pkg;

    // default table capacity
    localparam int MAX_EVENTS_DEF = 256;

    // operation codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // event actions
    localparam logic ACTION_ADVANCE = 1'b0;
    localparam logic ACTION_RESET   = 1'b1;

    // status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    // input item
    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] record_packet;
        logic [15:0] class_id;
        logic        action;
        logic [31:0] units;
        logic [15:0] window_start;
        logic [15:0] window_end;
    } req_item_t;

    // result item
    typedef struct packed {
        logic [31:0] progress_value;
        logic        status;
    } rsp_item_t;

    // one stored event
    typedef struct packed {
        logic        action;
        logic [15:0] class_id;
        logic [15:0] packet;
        logic [31:0] units;
    } entry_t;

    // chain control shared by every cell
    typedef struct packed {
        logic shift;
        logic rotate;
    } cell_ctrl_t;

    // query held for the length of a scan
    typedef struct packed {
        logic [15:0] class_id;
        logic [15:0] window_start;
        logic [15:0] window_end;
    } query_t;

    // accumulator control
    typedef struct packed {
        logic clear;
        logic enable;
    } acc_ctrl_t;

endpackage

FILE: design/cwpq_if.sv
// valid/ready channel interfaces for requests and results
interface cwpq_req_if
    import cwpq_pkg::*;
;
    logic      valid;
    logic      ready;
    req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cwpq_rsp_if
    import cwpq_pkg::*;
;
    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/cwpq_cell.sv
// one cell of the event chain: holds a single stored event
module cwpq_cell
    import cwpq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     shift_in,
    input  entry_t     rotate_in,
    output entry_t     entry
);

    entry_t entry_reg;

    // shift up on append, rotate down during a scan
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            entry_reg <= shift_in;
        end
        else if (ctrl.rotate)
        begin
            entry_reg <= rotate_in;
        end
    end

    assign entry = entry_reg;

endmodule

FILE: design/cwpq_accum.sv
// window test and saturating unit sum over the head of the chain
module cwpq_accum
    import cwpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  acc_ctrl_t   ctrl,
    input  query_t      query,
    input  entry_t      head,
    output logic [31:0] result
);

    logic [31:0] sum_reg;
    logic        hit_reset_reg;
    logic        match;
    logic [32:0] wide_sum;

    // event of the queried class strictly inside the window
    assign match = (head.class_id == query.class_id)
                && (head.packet > query.window_start)
                && (head.packet < query.window_end);

    assign wide_sum = {1'b0, sum_reg} + {1'b0, head.units};

    // accumulate one event per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            hit_reset_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            sum_reg       <= '0;
            hit_reset_reg <= 1'b0;
        end
        else if (ctrl.enable && match)
        begin
            if (head.action == ACTION_RESET)
            begin
                hit_reset_reg <= 1'b1;
            end
            else if (wide_sum[32])
            begin
                sum_reg <= '1;
            end
            else
            begin
                sum_reg <= wide_sum[31:0];
            end
        end
    end

    // a reset inside the window wins over any sum
    assign result = hit_reset_reg ? '1 : sum_reg;

endmodule

FILE: design/class_window_progress_query.sv
// Class window progress query: event table kept in a chain of cells.
// Append, clear and unused operations: result loaded into the output register as the item is taken.
// Query: the chain rotates once past the accumulator, one cell per cycle, then a finish state
// loads the result once the output register is free; one item at a time.
// Reset clears the event count and all control state; cell contents stay undefined,
// and no clearing pass is run.
module class_window_progress_query
    import cwpq_pkg::*;
#(
    parameter int MAX_EVENTS = MAX_EVENTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    cwpq_req_if.sink           req,
    cwpq_rsp_if.source         rsp
);

    localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int CNT_W = $clog2(MAX_EVENTS + 1);
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_EVENTS - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_EVENTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] step_reg;
    query_t           query_reg;
    logic             out_valid_reg;
    rsp_item_t        out_data_reg;

    logic        accept;
    logic        full;
    logic        out_free;
    logic        out_load;
    cell_ctrl_t  cell_ctrl;
    acc_ctrl_t   acc_ctrl;
    entry_t      new_entry;
    entry_t      cell_q [MAX_EVENTS];
    logic [31:0] acc_result;

    // handshake
    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept = req.valid && req.ready;
    assign full = (count_reg == FULL_COUNT);

    // output register loads when an item is finished
    assign out_load = (state_reg == ST_FINISH) ? out_free
                    : (accept && (req.data.operation != OP_QUERY));

    // event entering the chain
    assign new_entry.action   = req.data.action;
    assign new_entry.class_id = req.data.class_id;
    assign new_entry.packet   = req.data.record_packet;
    assign new_entry.units    = req.data.units;

    // chain control
    assign cell_ctrl.shift  = accept && (req.data.operation == OP_APPEND) && !full;
    assign cell_ctrl.rotate = (state_reg == ST_SCAN);

    // accumulator control: only occupied cells count
    assign acc_ctrl.clear  = accept && (req.data.operation == OP_QUERY);
    assign acc_ctrl.enable = (state_reg == ST_SCAN) && (CNT_W'(step_reg) < count_reg);

    // row of cells: shift towards the tail on append, rotate towards the head on scan
    for (genvar i = 0; i < MAX_EVENTS; i++)
    begin : g_cell
        localparam int NXT = (i + 1) % MAX_EVENTS;
        entry_t shift_src;

        if (i == 0)
        begin : g_first
            assign shift_src = new_entry;
        end
        else
        begin : g_rest
            assign shift_src = cell_q[i-1];
        end

        cwpq_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .shift_in  (shift_src),
            .rotate_in (cell_q[NXT]),
            .entry     (cell_q[i])
        );
    end

    // window test at the head of the chain
    cwpq_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .query  (query_reg),
        .head   (cell_q[0]),
        .result (acc_result)
    );

    // sequencer, event count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            query_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        out_data_reg.progress_value <= '0;
                        out_data_reg.status <= ((req.data.operation == OP_APPEND) && full)
                                             ? STATUS_DROPPED : STATUS_OK;
                        case (req.data.operation)
                            OP_APPEND:
                            begin
                                if (!full)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            OP_QUERY:
                            begin
                                query_reg.class_id     <= req.data.class_id;
                                query_reg.window_start <= req.data.window_start;
                                query_reg.window_end   <= req.data.window_end;
                                step_reg               <= '0;
                                state_reg              <= ST_SCAN;
                            end
                            OP_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            default:
                            begin
                                // unused operation: zero result only
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_data_reg.progress_value <= acc_result;
                        out_data_reg.status         <= STATUS_OK;
                        state_reg                   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

FILE: sim/window_progress_checker.sv
// checker that predicts and compares every result of the class window progress query block
module window_progress_checker
    import cwpq_pkg::*;
#(
    parameter int MAX_EVENTS = MAX_EVENTS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    cwpq_req_if  req,
    cwpq_rsp_if  rsp,
    output int   mismatches,
    output int   awaited,
    output int   drops_seen,
    output int   reset_hits,
    output int   saturated_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the event table
    entry_t    event_tbl [MAX_EVENTS];
    int        event_total;

    // results still owed by the block, oldest first
    rsp_item_t progress_due [$];

    // saturated unit sum of one class strictly inside the window, all-ones on a reset event
    function automatic logic [31:0] window_sum(input logic [15:0] cls,
                                               input logic [15:0] ws,
                                               input logic [15:0] we,
                                               output logic hit_reset,
                                               output logic saturated);
        logic [32:0] acc;
        acc = '0;
        hit_reset = 1'b0;
        saturated = 1'b0;
        if (ws >= we)
            return '0;
        for (int i = 0; i < event_total; i++)
        begin
            if (event_tbl[i].class_id != cls)
                continue;
            if (event_tbl[i].packet <= ws || event_tbl[i].packet >= we)
                continue;
            if (event_tbl[i].action == ACTION_RESET)
            begin
                hit_reset = 1'b1;
                return '1;
            end
            acc = acc + event_tbl[i].units;
            if (acc > 33'h0_FFFF_FFFF)
            begin
                acc = 33'h0_FFFF_FFFF;
                saturated = 1'b1;
            end
        end
        return acc[31:0];
    endfunction

    // update the shadow table with one item and return the result it should give
    function automatic rsp_item_t apply_item(input req_item_t it);
        rsp_item_t r;
        logic      rst_hit;
        logic      sat;
        r.progress_value = '0;
        r.status = STATUS_OK;
        case (it.operation)
            OP_APPEND:
            begin
                if (event_total >= MAX_EVENTS)
                begin
                    r.status = STATUS_DROPPED;
                    drops_seen++;
                end
                else
                begin
                    event_tbl[event_total].action   = it.action;
                    event_tbl[event_total].class_id = it.class_id;
                    event_tbl[event_total].packet   = it.record_packet;
                    event_tbl[event_total].units    = it.units;
                    event_total++;
                end
            end
            OP_QUERY:
            begin
                r.progress_value = window_sum(it.class_id, it.window_start,
                                              it.window_end, rst_hit, sat);
                if (rst_hit)
                    reset_hits++;
                if (sat)
                    saturated_hits++;
            end
            OP_CLEAR:
                event_total = 0;
            default:
                ;
        endcase
        return r;
    endfunction

    // one line per mismatch, printing capped so a broken block cannot flood the log
    task automatic report_mismatch(input string msg);
        if (mismatches < 100)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // results are matched before new items are predicted, as they belong to older items
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        rsp_item_t want;
        if (!rst_n)
        begin
            event_total = 0;
            progress_due.delete();
            mismatches = 0;
            awaited = 0;
            drops_seen = 0;
            reset_hits = 0;
            saturated_hits = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (progress_due.size() == 0)
                begin
                    report_mismatch($sformatf("result 0x%08h/%0b with no item waiting",
                                              rsp.data.progress_value, rsp.data.status));
                end
                else
                begin
                    want = progress_due.pop_front();
                    if (rsp.data.progress_value !== want.progress_value)
                        report_mismatch($sformatf("progress_value 0x%08h, expected 0x%08h",
                                                  rsp.data.progress_value,
                                                  want.progress_value));
                    if (rsp.data.status !== want.status)
                        report_mismatch($sformatf("status %0b, expected %0b",
                                                  rsp.data.status, want.status));
                end
            end
            if (req.valid && req.ready)
                progress_due.push_back(apply_item(req.data));
            awaited = progress_due.size();
        end
    end

endmodule

FILE: sim/tb_top.sv
// testbench top: stimulus, handshake idling, watchdog and verdict for the progress query block
module tb_top
    import cwpq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         MAX_EVENTS   = MAX_EVENTS_DEF;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 1550;
    localparam int         LONG_GAP     = 30;
    // a query holds the block for a full scan, with both sides idling on top
    localparam int         IDLE_LIMIT   = 4 * (MAX_EVENTS + 1 + 2 * LONG_GAP + 16);

    logic clk;
    logic rst_n;
    bit   gapless;

    int mismatches;
    int awaited;
    int drops_seen;
    int reset_hits;
    int saturated_hits;

    int items_sent;
    int appends_sent;
    int queries_sent;
    int clears_sent;
    int unused_sent;
    int idle_cycles;

    // episode state for the random part
    int          cursor;
    int          base_pkt;
    logic [15:0] class_pool [4];
    int          pool_size;

    cwpq_req_if req_ch ();
    cwpq_rsp_if rsp_ch ();

    class_window_progress_query #(
        .MAX_EVENTS (MAX_EVENTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    window_progress_checker #(
        .MAX_EVENTS (MAX_EVENTS)
    ) progress_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatches     (mismatches),
        .awaited        (awaited),
        .drops_seen     (drops_seen),
        .reset_hits     (reset_hits),
        .saturated_hits (saturated_hits)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (gapless)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, LONG_GAP);
    endfunction

    // result side stalls
    initial
    begin : result_stalls
        int busy;
        int gap;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            busy = $urandom_range(1, 12);
            gap = pick_gap();
            rsp_ch.ready <= 1'b1;
            repeat (busy) @(posedge clk);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // watchdog on handshakes of either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: %0d cycles without a handshake, %0d results owed",
                         idle_cycles, awaited);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // all fields random, so that unused fields are exercised too
    function automatic req_item_t random_fill();
        req_item_t it;
        it.operation     = 2'($urandom_range(0, 3));
        it.record_packet = 16'($urandom_range(0, 65535));
        it.class_id      = 16'($urandom_range(0, 65535));
        it.action        = 1'($urandom_range(0, 1));
        it.units         = $urandom;
        it.window_start  = 16'($urandom_range(0, 65535));
        it.window_end    = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    // present one item after an optional gap and hold it until taken
    task automatic send_item(input req_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= it;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        case (it.operation)
            OP_APPEND: appends_sent++;
            OP_QUERY:  queries_sent++;
            OP_CLEAR:  clears_sent++;
            default:   unused_sent++;
        endcase
        if (it.operation != OP_UNUSED)
            items_sent++;
    endtask

    task automatic send_append(input logic [15:0] pkt, input logic [15:0] cls,
                               input logic act, input logic [31:0] units);
        req_item_t it;
        it = random_fill();
        it.operation = OP_APPEND;
        it.record_packet = pkt;
        it.class_id = cls;
        it.action = act;
        it.units = units;
        send_item(it);
    endtask

    task automatic send_query(input logic [15:0] cls, input logic [15:0] ws,
                              input logic [15:0] we);
        req_item_t it;
        it = random_fill();
        it.operation = OP_QUERY;
        it.class_id = cls;
        it.window_start = ws;
        it.window_end = we;
        send_item(it);
    endtask

    task automatic send_op(input logic [1:0] op);
        req_item_t it;
        it = random_fill();
        it.operation = op;
        send_item(it);
    endtask

    // class ids lean on the extremes
    function automatic logic [15:0] pick_class();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 16'h0000;
        if (r < 25)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // units mix zero, all-ones, wide values and small counts
    function automatic logic [31:0] pick_units();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'h0;
        if (r < 20)
            return 32'hFFFF_FFFF;
        if (r < 45)
            return $urandom;
        if (r < 55)
            return 32'h8000_0000 | $urandom;
        return 32'($urandom_range(0, 1000));
    endfunction

    // append at the packet cursor, or behind it when out of order
    task automatic append_event(input bit backwards);
        logic [15:0] pkt;
        logic        act;
        if (backwards)
        begin
            pkt = 16'($urandom_range(base_pkt, cursor));
        end
        else
        begin
            cursor = cursor + $urandom_range(0, 3);
            if (cursor > 65535)
                cursor = 65535;
            pkt = 16'(cursor);
        end
        act = ($urandom_range(0, 99) < 8) ? ACTION_RESET : ACTION_ADVANCE;
        send_append(pkt, class_pool[$urandom_range(0, pool_size - 1)], act, pick_units());
    endtask

    // query mostly around the packets of this episode
    task automatic query_window();
        logic [15:0] cls;
        int          ws;
        int          we;
        int          r;
        cls = ($urandom_range(0, 99) < 85) ? class_pool[$urandom_range(0, pool_size - 1)]
                                          : pick_class();
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            ws = $urandom_range(0, 65535);
            we = $urandom_range(0, ws);
        end
        else if (r < 20)
        begin
            ws = $urandom_range(0, 65535);
            we = $urandom_range(0, 65535);
        end
        else
        begin
            ws = $urandom_range((base_pkt > 2) ? base_pkt - 2 : 0, cursor);
            we = ws + $urandom_range(0, cursor - base_pkt + 4);
            if (we > 65535)
                we = 65535;
        end
        send_query(cls, 16'(ws), 16'(we));
    endtask

    // one episode: usually a fresh table, then appends mixed with queries
    task automatic run_episode(input bit fill);
        int target;
        int appends;
        int ops;
        int r;
        gapless = ($urandom_range(0, 4) == 0);
        pool_size = $urandom_range(1, 4);
        for (int i = 0; i < 4; i++)
            class_pool[i] = pick_class();
        cursor = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 2000)
                                              : $urandom_range(0, 65535);
        base_pkt = cursor;
        if (fill || $urandom_range(0, 99) < 85)
            send_op(OP_CLEAR);
        if (fill)
        begin
            // run the table close to, and often past, its capacity
            target = $urandom_range(250, 275);
            appends = 0;
            while (appends < target)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    append_event(1'b0);
                    appends++;
                end
                else
                begin
                    query_window();
                end
            end
        end
        else
        begin
            ops = $urandom_range(4, 60);
            repeat (ops)
            begin
                r = $urandom_range(0, 99);
                if (r < 48)
                    append_event(1'b0);
                else if (r < 86)
                    query_window();
                else if (r < 90)
                    send_op(OP_CLEAR);
                else if (r < 95)
                    send_op(OP_UNUSED);
                else
                    append_event(1'b1);
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        int directed_count;
        int episode;
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        rst_n <= 1'b0;
        gapless = 1'b0;
        idle_cycles = 0;
        items_sent = 0;
        appends_sent = 0;
        queries_sent = 0;
        clears_sent = 0;
        unused_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, clear and unused operation
        send_query(16'h0000, 16'h0000, 16'hFFFF);
        send_op(OP_CLEAR);
        send_op(OP_UNUSED);

        // small table with extreme fields, one reset and two out of order events
        send_append(16'd10, 16'h0000, ACTION_ADVANCE, 32'hFFFF_FFFF);
        send_append(16'd11, 16'h0000, ACTION_ADVANCE, 32'd2);
        send_append(16'd12, 16'hFFFF, ACTION_ADVANCE, 32'd7);
        send_append(16'd20, 16'hFFFF, ACTION_RESET, 32'h1234_5678);
        send_append(16'hFFFF, 16'hAAAA, ACTION_ADVANCE, 32'h5555_5555);
        send_append(16'd5, 16'h5555, ACTION_ADVANCE, 32'd9);
        send_append(16'd0, 16'h5555, ACTION_ADVANCE, 32'd3);

        // sum overflow
        send_query(16'h0000, 16'd9, 16'd13);
        send_query(16'h0000, 16'd0, 16'd12);
        // no event strictly inside
        send_query(16'h0000, 16'd10, 16'd11);
        // empty and inverted windows
        send_query(16'h0000, 16'd11, 16'd11);
        send_query(16'h0000, 16'd13, 16'd9);
        send_query(16'h0000, 16'hFFFF, 16'h0000);
        // reset inside the window, then just outside it
        send_query(16'hFFFF, 16'd11, 16'd21);
        send_query(16'hFFFF, 16'd11, 16'd20);
        // unknown class, edges of the packet range
        send_query(16'h1234, 16'h0000, 16'hFFFF);
        send_query(16'h5555, 16'h0000, 16'hFFFF);
        send_query(16'hAAAA, 16'h0000, 16'hFFFF);

        send_op(OP_CLEAR);
        send_query(16'h0000, 16'd0, 16'd100);
        directed_count = items_sent;

        // random episodes, a few of them filling the table close to or past its capacity
        episode = 0;
        while (items_sent < directed_count + RANDOM_ITEMS)
        begin
            run_episode((episode % 12 == 4) || ($urandom_range(0, 99) < 3));
            episode++;
        end
        req_ch.valid <= 1'b0;

        // drain, then allow one more scan for stray results
        while (awaited != 0)
            @(posedge clk);
        repeat (MAX_EVENTS + 8) @(posedge clk);

        $display("covered %0d appends (%0d dropped on a full table) and %0d queries", appends_sent,
                 drops_seen, queries_sent);
        $display("  %0d queries hit a reset event, %0d saturated; %0d clears, %0d unused ops",
                 reset_hits, saturated_hits, clears_sent, unused_sent);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
